FILE: sv/lens_undistort_source_map_macros.svh
// ----------------------------------------------------------------------------
// lens undistort source map assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef LENS_UNDISTORT_SOURCE_MAP_MACROS_SVH
`define LENS_UNDISTORT_SOURCE_MAP_MACROS_SVH

// antecedent in one cycle implies consequent in the next
`define LUSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// antecedent implies consequent in the same cycle
`define LUSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/lusm_pkg.sv
// ----------------------------------------------------------------------------
// lusm_pkg
// register indexes and fixed-point helpers for the undistort source map
// ----------------------------------------------------------------------------
package lusm_pkg;

  typedef logic [2:0] cfg_addr_t;

  localparam cfg_addr_t REG_FOCAL_X = 3'd0;
  localparam cfg_addr_t REG_FOCAL_Y = 3'd1;
  localparam cfg_addr_t REG_CENTER_X = 3'd2;
  localparam cfg_addr_t REG_CENTER_Y = 3'd3;
  localparam cfg_addr_t REG_K1 = 3'd4;
  localparam cfg_addr_t REG_K2 = 3'd5;
  localparam cfg_addr_t REG_P1 = 3'd6;
  localparam cfg_addr_t REG_P2 = 3'd7;

  localparam int unsigned DIV_BITS = 49;
  localparam int unsigned PIX_SHIFT = 36;
  localparam logic signed [63:0] ONE_Q28 = 64'sd268435456;

  // arithmetic shift right rounding toward zero
  function automatic logic signed [63:0] shr_trunc(input logic signed [63:0] p,
                                                   input int unsigned k);
    logic signed [63:0] bias;
    bias = p[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (p + bias) >>> k;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/lens_undistort_source_map.sv
// ----------------------------------------------------------------------------
// lens_undistort_source_map
// maps each output pixel to its source pixel through a radial and
// tangential lens distortion model
// ----------------------------------------------------------------------------
// Takes one output pixel coordinate per clock unless the result side
// stalls and returns the distorted source pixel and an in-frame flag. The
// pipeline is made up of the two 49-step pipelined dividers that normalize
// column and row by the focal lengths, followed by a 15-stage multiply
// chain. Configuration registers are used live by the stages; the user must
// write them only with the pipeline empty, which the block does not enforce.
// Backpressure on the result side stalls the whole pipeline.
module lens_undistort_source_map #(
  parameter int FRAME_WIDTH = 1024,
  parameter int FRAME_HEIGHT = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  lusm_pkg::cfg_addr_t cfg_addr,
  input  logic [31:0]        cfg_data,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [23:0]        s_tdata,   // out_col[9:0], out_row[19:10], zero pad
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [23:0]        m_tdata,   // src_col[9:0], src_row[19:10], zero pad
  output logic               m_tuser    // in_frame
);
  import lusm_pkg::*;

  localparam int unsigned LAT = DIV_BITS + 16;
  localparam logic signed [55:0] LIM_X = 56'(FRAME_WIDTH) <<< PIX_SHIFT;
  localparam logic signed [55:0] LIM_Y = 56'(FRAME_HEIGHT) <<< PIX_SHIFT;

  logic [19:0] focal_x, focal_y, center_x, center_y;
  logic signed [31:0] radial_k1, radial_k2, tangential_p1, tangential_p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x <= 20'd117415;
      focal_y <= 20'd117068;
      center_x <= 20'd94007;
      center_y <= 20'd63584;
      radial_k1 <= -32'sd304307142;
      radial_k2 <= 32'sd79412953;
      tangential_p1 <= 32'sd207866;
      tangential_p2 <= 32'sd18918;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FOCAL_X:  focal_x <= cfg_data[19:0];
        REG_FOCAL_Y:  focal_y <= cfg_data[19:0];
        REG_CENTER_X: center_x <= cfg_data[19:0];
        REG_CENTER_Y: center_y <= cfg_data[19:0];
        REG_K1:       radial_k1 <= cfg_data;
        REG_K2:       radial_k2 <= cfg_data;
        REG_P1:       tangential_p1 <= cfg_data;
        REG_P2:       tangential_p2 <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  logic en;
  logic vld [0:LAT-1];

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int i = 1; i < LAT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // offset from the principal point, split into sign and magnitude
  logic signed [21:0] dx_c, dy_c;
  logic [19:0] xrem [0:DIV_BITS];
  logic [19:0] yrem [0:DIV_BITS];
  logic [48:0] xnum [0:DIV_BITS];
  logic [48:0] ynum [0:DIV_BITS];
  logic [31:0] xq [0:DIV_BITS];
  logic [31:0] yq [0:DIV_BITS];
  logic xovf [0:DIV_BITS];
  logic yovf [0:DIV_BITS];
  logic xneg [0:DIV_BITS];
  logic yneg [0:DIV_BITS];

  assign dx_c = $signed({4'b0, s_tdata[9:0], 8'b0}) - $signed({2'b0, center_x});
  assign dy_c = $signed({4'b0, s_tdata[19:10], 8'b0}) - $signed({2'b0, center_y});

  always_ff @(posedge clk) begin
    if (en) begin
      xrem[0] <= '0;
      yrem[0] <= '0;
      xq[0] <= '0;
      yq[0] <= '0;
      xovf[0] <= 1'b0;
      yovf[0] <= 1'b0;
      xneg[0] <= dx_c[21];
      yneg[0] <= dy_c[21];
      xnum[0] <= {(dx_c[21] ? 21'(-dx_c) : dx_c[20:0]), 28'b0};
      ynum[0] <= {(dy_c[21] ? 21'(-dy_c) : dy_c[20:0]), 28'b0};
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
    logic [20:0] xsh, ysh;
    logic xge, yge;
    assign xsh = {xrem[g], xnum[g][48]};
    assign ysh = {yrem[g], ynum[g][48]};
    assign xge = xsh >= {1'b0, focal_x};
    assign yge = ysh >= {1'b0, focal_y};
    always_ff @(posedge clk) begin
      if (en) begin
        xrem[g+1] <= xge ? 20'(xsh - {1'b0, focal_x}) : xsh[19:0];
        yrem[g+1] <= yge ? 20'(ysh - {1'b0, focal_y}) : ysh[19:0];
        xnum[g+1] <= {xnum[g][47:0], 1'b0};
        ynum[g+1] <= {ynum[g][47:0], 1'b0};
        xq[g+1] <= {xq[g][30:0], xge};
        yq[g+1] <= {yq[g][30:0], yge};
        xovf[g+1] <= xovf[g] | xq[g][31];
        yovf[g+1] <= yovf[g] | yq[g][31];
        xneg[g+1] <= xneg[g];
        yneg[g+1] <= yneg[g];
      end
    end
  end

  logic [31:0] qx, qy;
  assign qx = xq[DIV_BITS];
  assign qy = yq[DIV_BITS];

  logic signed [31:0] x_n, y_n, x_a, y_a, x_b, y_b, x_c, y_c, x_d, y_d;
  logic signed [31:0] x_e, y_e, x_f, y_f, x_g, y_g, x_h, y_h;
  logic signed [63:0] x2p, y2p, xyp;
  logic signed [31:0] x2, y2, xy, xy_c, xy_d;
  logic signed [31:0] x2_c;
  logic signed [31:0] y2_c;
  logic signed [31:0] r2, r2_d, r4;
  logic signed [63:0] r4p, k1r2p, k2r4p, p1xyp, p2txp, p1typ, p2xyp;
  logic signed [31:0] tx, ty, tx_e;
  logic signed [31:0] ty_e;
  logic signed [63:0] k1t, k1t_f, k1t_g, k2t, t1x, t2x, t1y, t2y;
  logic signed [63:0] t1x_g, t2x_g, t1y_g, t2y_g, t1x_h, t2x_h, t1y_h, t2y_h;
  logic signed [63:0] t1x_i, t2y_i;
  logic signed [31:0] rad;
  logic signed [63:0] xrp, yrp, xr, yr;
  logic signed [31:0] xd, yd;
  logic signed [55:0] scx, scy, sx, sy;

  always_ff @(posedge clk) begin
    if (en) begin
      // quotient sign and clamp to q4.28
      if (!xneg[DIV_BITS]) begin
        x_n <= (xovf[DIV_BITS] || qx[31]) ? 32'sh7fffffff : $signed(qx);
      end else begin
        x_n <= (xovf[DIV_BITS] || qx > 32'h80000000) ? 32'sh80000000 : $signed(-qx);
      end
      if (!yneg[DIV_BITS]) begin
        y_n <= (yovf[DIV_BITS] || qy[31]) ? 32'sh7fffffff : $signed(qy);
      end else begin
        y_n <= (yovf[DIV_BITS] || qy > 32'h80000000) ? 32'sh80000000 : $signed(-qy);
      end

      x2p <= 64'(x_n) * 64'(x_n);
      y2p <= 64'(y_n) * 64'(y_n);
      xyp <= 64'(x_n) * 64'(y_n);
      x_a <= x_n;
      y_a <= y_n;

      x2 <= sat32(shr_trunc(x2p, 28));
      y2 <= sat32(shr_trunc(y2p, 28));
      xy <= sat32(shr_trunc(xyp, 28));
      x_b <= x_a;
      y_b <= y_a;

      r2 <= sat32(64'(x2) + 64'(y2));
      x2_c <= x2;
      y2_c <= y2;
      xy_c <= xy;
      x_c <= x_b;
      y_c <= y_b;

      r4p <= 64'(r2) * 64'(r2);
      k1r2p <= 64'(radial_k1) * 64'(r2);
      tx <= sat32(64'(r2) + (64'(x2_c) <<< 1));
      ty <= sat32(64'(r2) + (64'(y2_c) <<< 1));
      r2_d <= r2;
      xy_d <= xy_c;
      x_d <= x_c;
      y_d <= y_c;

      r4 <= sat32(shr_trunc(r4p, 28));
      k1t <= shr_trunc(k1r2p, 30);
      tx_e <= tx;
      ty_e <= ty;
      p1xyp <= 64'(tangential_p1) * 64'(xy_d);
      p2xyp <= 64'(tangential_p2) * 64'(xy_d);
      x_e <= x_d;
      y_e <= y_d;

      k2r4p <= 64'(radial_k2) * 64'(r4);
      p2txp <= 64'(tangential_p2) * 64'(tx_e);
      p1typ <= 64'(tangential_p1) * 64'(ty_e);
      t1x <= shr_trunc(p1xyp, 29);
      t2y <= shr_trunc(p2xyp, 29);
      k1t_f <= k1t;
      x_f <= x_e;
      y_f <= y_e;

      k2t <= shr_trunc(k2r4p, 30);
      t2x <= shr_trunc(p2txp, 30);
      t1y <= shr_trunc(p1typ, 30);
      k1t_g <= k1t_f;
      t1x_g <= t1x;
      t2y_g <= t2y;
      x_g <= x_f;
      y_g <= y_f;

      rad <= sat32(ONE_Q28 + k1t_g + k2t);
      t1x_h <= t1x_g;
      t2x_g <= t2x;
      t1y_g <= t1y;
      t2y_h <= t2y_g;
      x_h <= x_g;
      y_h <= y_g;

      xrp <= 64'(x_h) * 64'(rad);
      yrp <= 64'(y_h) * 64'(rad);
      t1x_i <= t1x_h;
      t2x_h <= t2x_g;
      t1y_h <= t1y_g;
      t2y_i <= t2y_h;

      xr <= shr_trunc(xrp, 28) + t1x_i + t2x_h;
      yr <= shr_trunc(yrp, 28) + t1y_h + t2y_i;

      xd <= sat32(xr);
      yd <= sat32(yr);

      scx <= 56'($signed({1'b0, focal_x})) * 56'(xd);
      scy <= 56'($signed({1'b0, focal_y})) * 56'(yd);

      sx <= scx + $signed({8'b0, center_x, 28'b0});
      sy <= scy + $signed({8'b0, center_y, 28'b0});
    end
  end

  logic okx, oky, ok;
  assign okx = !sx[55] && (sx < LIM_X);
  assign oky = !sy[55] && (sy < LIM_Y);
  assign ok = okx && oky && (focal_x != 20'd0) && (focal_y != 20'd0);

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= ok ? {4'b0, sy[45:36], sx[45:36]} : 24'd0;
      m_tuser <= ok;
    end
  end

endmodule

FILE: sv/lusm_checker.sv
// ----------------------------------------------------------------------------
// lusm_checker
// port-level checks for the undistort source map
// ----------------------------------------------------------------------------
module lusm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser
);
  `include "lens_undistort_source_map_macros.svh"

  `LUSM_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `LUSM_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  `LUSM_ASSERT_NOW(a_outside_zero, m_tvalid && !m_tuser, m_tdata == 24'd0, "outside source not zero")
  `LUSM_ASSERT_NOW(a_ready_follows, 1'b1, s_tready == (!m_tvalid || m_tready), "input ready does not track output")

endmodule

bind lens_undistort_source_map lusm_checker u_lusm_checker (.*);

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lens undistort source map testbench
// drives pixel coordinates with bursty traffic and a stalling result side,
// predicts each source pixel in fixed point and compares every result
// ----------------------------------------------------------------------------
module testbench;
  import lusm_pkg::*;

  localparam int FW = 1024;
  localparam int FH = 1024;
  localparam int LATENCY = 65;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [9:0] col;
    logic [9:0] row;
    logic       in_frame;
  } src_pixel_t;

  typedef struct {
    logic [9:0] col;
    logic [9:0] row;
    logic       known;
    src_pixel_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  cfg_addr_t cfg_addr = REG_FOCAL_X;
  logic [31:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic m_tuser;

  lens_undistort_source_map #(.FRAME_WIDTH(FW), .FRAME_HEIGHT(FH)) i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of the registers
  logic [19:0] fx, fy, cx, cy;
  logic signed [63:0] k1, k2, p1, p2;

  src_pixel_t expected_pixels[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_off = 0;
  bit stall_mode = 0;

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] norm_q28(input logic [9:0] pix,
                                                  input logic [19:0] c,
                                                  input logic [19:0] f);
    logic signed [63:0] d;
    d = $signed({46'd0, pix, 8'd0}) - $signed({44'd0, c});
    return clamp32((d * 64'sd268435456) / $signed({44'd0, f}));
  endfunction

  function automatic bit to_index(input logic signed [63:0] nd, input logic [19:0] f,
                                  input logic [19:0] c, input int lim,
                                  output logic [9:0] idx);
    logic signed [63:0] s;
    s = $signed({44'd0, f}) * nd + $signed({44'd0, c}) * 64'sd268435456;
    idx = '0;
    if (s < 0 || s >= (64'(lim) <<< 36)) return 0;
    idx = s[45:36];
    return 1;
  endfunction

  function automatic src_pixel_t source_pixel(input logic [9:0] col, input logic [9:0] row);
    logic signed [63:0] x, y, x2, y2, xy, r2, r4, rad, tx, ty, xd, yd;
    logic [9:0] sc, sr;
    bit okc, okr;
    src_pixel_t res;
    res = '0;
    if (fx == 0 || fy == 0) return res;
    x = norm_q28(col, cx, fx);
    y = norm_q28(row, cy, fy);
    x2 = clamp32((x * x) / 64'sd268435456);
    y2 = clamp32((y * y) / 64'sd268435456);
    xy = clamp32((x * y) / 64'sd268435456);
    r2 = clamp32(x2 + y2);
    r4 = clamp32((r2 * r2) / 64'sd268435456);
    rad = clamp32(64'sd268435456 + (k1 * r2) / 64'sd1073741824
                  + (k2 * r4) / 64'sd1073741824);
    tx = clamp32(r2 + 2 * x2);
    ty = clamp32(r2 + 2 * y2);
    xd = clamp32((x * rad) / 64'sd268435456 + (p1 * xy) / 64'sd536870912
                 + (p2 * tx) / 64'sd1073741824);
    yd = clamp32((y * rad) / 64'sd268435456 + (p1 * ty) / 64'sd1073741824
                 + (p2 * xy) / 64'sd536870912);
    okc = to_index(xd, fx, cx, FW, sc);
    okr = to_index(yd, fy, cy, FH, sr);
    if (okc && okr) begin
      res.col = sc;
      res.row = sr;
      res.in_frame = 1'b1;
    end
    return res;
  endfunction

  task automatic write_reg(input cfg_addr_t a, input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (a)
      REG_FOCAL_X: fx = v[19:0];
      REG_FOCAL_Y: fy = v[19:0];
      REG_CENTER_X: cx = v[19:0];
      REG_CENTER_Y: cy = v[19:0];
      REG_K1: k1 = $signed(v);
      REG_K2: k2 = $signed(v);
      REG_P1: p1 = $signed(v);
      default: p2 = $signed(v);
    endcase
  endtask

  task automatic drain_pipeline();
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // one coordinate transaction; valid stays high across back-to-back items
  task automatic send_pixel(input logic [9:0] col, input logic [9:0] row,
                            input bit known, input src_pixel_t want);
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, row, col};
    do @(posedge clk); while (!s_tready);
    expected_pixels.push_back(known ? want : source_pixel(col, row));
  endtask

  task automatic random_phase(input int n);
    int burst;
    int gap;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 40);
      end
      burst--;
      send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023), 0, '0);
    end
    s_tvalid <= 1'b0;
  endtask

  task automatic random_config(input bit extreme);
    write_reg(REG_FOCAL_X, extreme ? $urandom_range(0, 1) * 20'hfffff + 1
                                   : $urandom_range(40000, 300000));
    write_reg(REG_FOCAL_Y, extreme ? $urandom_range(1, 300) : $urandom_range(40000, 300000));
    write_reg(REG_CENTER_X, extreme ? 20'hfffff : $urandom_range(0, 262143));
    write_reg(REG_CENTER_Y, extreme ? 20'h0 : $urandom_range(0, 262143));
    write_reg(REG_K1, extreme ? 32'h80000000 : $urandom);
    write_reg(REG_K2, extreme ? 32'h7fffffff : $urandom);
    write_reg(REG_P1, $urandom);
    write_reg(REG_P2, $urandom);
  endtask

  // result side: check each transaction against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h/%b", m_tdata, m_tuser);
      end else begin
        src_pixel_t w;
        w = expected_pixels.pop_front();
        if (m_tdata !== {4'd0, w.row, w.col} || m_tuser !== w.in_frame) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want col %0d row %0d in %b, got col %0d row %0d in %b",
                     w.col, w.row, w.in_frame, m_tdata[9:0], m_tdata[19:10], m_tuser);
        end
      end
    end
  end

  // receiver stall pattern with an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off) begin
      m_tready <= 1'b0;
    end else if (stall_mode) begin
      m_tready <= ($urandom_range(0, 3) != 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watchdog on stretches with no transaction
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst || hold_off)
      idle_cycles <= 0;
    else if (expected_pixels.size() != 0 || s_tvalid)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_rows[$];
    fx = 20'd117415; fy = 20'd117068; cx = 20'd94007; cy = 20'd63584;
    k1 = -64'sd304307142; k2 = 64'sd79412953; p1 = 64'sd207866; p2 = 64'sd18918;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners and interior points with reset settings
    dir_rows.push_back('{10'd0, 10'd0, 0, '0});
    dir_rows.push_back('{10'd1023, 10'd0, 0, '0});
    dir_rows.push_back('{10'd0, 10'd1023, 0, '0});
    dir_rows.push_back('{10'd1023, 10'd1023, 0, '0});
    dir_rows.push_back('{10'd367, 10'd248, 0, '0});
    dir_rows.push_back('{10'd512, 10'd512, 0, '0});
    dir_rows.push_back('{10'h2aa, 10'h155, 0, '0});
    dir_rows.push_back('{10'h155, 10'h2aa, 0, '0});
    foreach (dir_rows[i])
      send_pixel(dir_rows[i].col, dir_rows[i].row, dir_rows[i].known, dir_rows[i].want);
    s_tvalid <= 1'b0;
    drain_pipeline();

    // zero focal length: every pixel outside
    write_reg(REG_FOCAL_X, 20'd0);
    send_pixel(10'd367, 10'd248, 1, '0);
    send_pixel(10'd1023, 10'd1023, 1, '0);
    s_tvalid <= 1'b0;
    drain_pipeline();
    write_reg(REG_FOCAL_X, 20'd117415);
    write_reg(REG_FOCAL_Y, 20'd0);
    send_pixel(10'd0, 10'd0, 1, '0);
    s_tvalid <= 1'b0;
    drain_pipeline();

    // identity lens: source equals destination
    write_reg(REG_FOCAL_Y, 20'd117068);
    write_reg(REG_K1, 32'd0);
    write_reg(REG_K2, 32'd0);
    write_reg(REG_P1, 32'd0);
    write_reg(REG_P2, 32'd0);
    send_pixel(10'd0, 10'd0, 1, '{10'd0, 10'd0, 1'b1});
    send_pixel(10'd1023, 10'd1023, 0, '0);
    send_pixel(10'd100, 10'd900, 0, '0);
    s_tvalid <= 1'b0;
    drain_pipeline();

    // saturation: tiny focal lengths and extreme coefficients
    random_config(1);
    send_pixel(10'd0, 10'd1023, 0, '0);
    send_pixel(10'd1023, 10'd0, 0, '0);
    send_pixel(10'd511, 10'd511, 0, '0);
    s_tvalid <= 1'b0;
    drain_pipeline();

    // reset settings, long output hold-off while input keeps offering
    write_reg(REG_FOCAL_X, 20'd117415); write_reg(REG_FOCAL_Y, 20'd117068);
    write_reg(REG_CENTER_X, 20'd94007); write_reg(REG_CENTER_Y, 20'd63584);
    write_reg(REG_K1, -32'sd304307142); write_reg(REG_K2, 32'sd79412953);
    write_reg(REG_P1, 32'sd207866); write_reg(REG_P2, 32'sd18918);
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      random_phase(200);
    join
    drain_pipeline();

    stall_mode = 1;
    random_phase(500);
    drain_pipeline();
    for (int ph = 0; ph < 3; ph++) begin
      random_config(ph == 2);
      stall_mode = ph[0];
      random_phase(300);
      drain_pipeline();
    end

    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+sv
sv/lusm_pkg.sv
sv/lens_undistort_source_map.sv
sv/lusm_checker.sv
tb/sv/testbench.sv
